### src/ssbs_pkg.sv
// Shared types, constants and pattern helpers for the styled square brush stamp.
`default_nettype none
package ssbs_pkg;

  localparam int MAX_CANVAS_DEF     = 4096;
  localparam int MAX_LINE_WIDTH_DEF = 64;

  localparam int IN_DATA_W  = 64;   // point_x, point_y, color
  localparam int OUT_DATA_W = 112;  // 109 used bits, zero filled
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PHASE_W    = 11;
  localparam int LW_W       = 7;
  localparam int DIM_W      = 13;
  localparam int ADDR_W     = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CANVAS_WIDTH  = 3'd0,
    REG_CANVAS_HEIGHT = 3'd1,
    REG_LINE_WIDTH    = 3'd2,
    REG_LINE_STYLE    = 3'd3,
    REG_OBJECT_ID     = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    STYLE_SOLID    = 2'd0,
    STYLE_DASHED   = 2'd1,
    STYLE_DOTTED   = 2'd2,
    STYLE_RESERVED = 2'd3
  } style_t;

  localparam logic OP_PLOT    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CALC = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  function automatic logic [PHASE_W-1:0] pattern_period(input logic [1:0] style,
                                                        input logic [LW_W-1:0] w);
    logic [PHASE_W-1:0] ww;
    ww = PHASE_W'(w);
    case (style)
      STYLE_DASHED: pattern_period = 11'd22 * ww + 11'd2;
      STYLE_DOTTED: pattern_period = 11'd18 * ww + PHASE_W'(w[LW_W-1:1]) + 11'd4;
      default:      pattern_period = 11'd1;
    endcase
  endfunction

  function automatic logic phase_on(input logic [1:0] style, input logic [LW_W-1:0] w,
                                    input logic [PHASE_W-1:0] p);
    logic [PHASE_W-1:0] ww, a, b, c;
    ww = PHASE_W'(w);
    a  = 11'd3 * ww + 11'd1;
    b  = a + PHASE_W'(w[LW_W-1:1]) + 11'd1;
    c  = b + a;
    case (style)
      STYLE_DASHED: phase_on = p >= (11'd7 * ww + 11'd1);
      STYLE_DOTTED: phase_on = (p >= a && p < b) || p >= c;
      default:      phase_on = 1'b1;
    endcase
  endfunction

  // clip a signed coordinate into [0, hi]
  function automatic logic [DIM_W-1:0] clip_dim(input logic signed [17:0] v,
                                                input logic [DIM_W-1:0] hi);
    if (v < 0)
      clip_dim = '0;
    else if (v > $signed({5'b0, hi}))
      clip_dim = hi;
    else
      clip_dim = v[DIM_W-1:0];
  endfunction

endpackage
`default_nettype wire

### src/styled_square_brush_stamp_core.sv
// Styled square brush stamp: stipple phase, square clip and per-row span emit.
//
// Each input word is a plot or a pattern advance. An advance, or a plot whose
// stipple phase is off, is taken with no span. A plot that is on passes
// capture, clip and start address by one multiply, then emits up to line_width
// clipped rows, one per cycle while the output takes them; each row steps the
// row by one and the start address by the stride, its span held in the output
// register until taken. Input is not ready until its last span is taken.
`default_nettype none
module styled_square_brush_stamp_core #(
  parameter int MAX_CANVAS     = ssbs_pkg::MAX_CANVAS_DEF,
  parameter int MAX_LINE_WIDTH = ssbs_pkg::MAX_LINE_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [ssbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ssbs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // point_x[15:0], point_y[31:16], color[63:32]
  input  wire logic [ssbs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // opcode
  input  wire logic                            s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // row_y[11:0], span_start[23:12], span_end[36:24], row_start_address[60:37],
  // pixel_color[92:61], object_id_out[108:93], zero[111:109]
  output logic [ssbs_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                                 m_axis_tlast
);
  import ssbs_pkg::*;

  state_t              state;
  logic [DIM_W-1:0]    canvas_width, canvas_height;
  logic [LW_W-1:0]     line_width;
  logic [1:0]          line_style;
  logic [15:0]         object_id;
  logic [PHASE_W-1:0]  phase, phase_inc;
  logic signed [15:0]  cx, cy;
  logic [31:0]         color;
  logic [DIM_W-1:0]    x0, x1, row, y1, stride;
  logic [ADDR_W-1:0]   addr;

  logic [LW_W-1:0]     w;
  logic [DIM_W-1:0]    wclip, hclip;
  logic [LW_W-1:0]     half;
  logic signed [17:0]  sx, sy;
  logic                s_acc, m_acc, last_row;

  assign w = (line_width > LW_W'(MAX_LINE_WIDTH)) ? LW_W'(MAX_LINE_WIDTH) : line_width;
  assign wclip = ({2'b0, canvas_width} > 15'(MAX_CANVAS)) ? DIM_W'(MAX_CANVAS) : canvas_width;
  assign hclip = ({2'b0, canvas_height} > 15'(MAX_CANVAS)) ? DIM_W'(MAX_CANVAS) : canvas_height;
  assign half = {1'b0, w[LW_W-1:1]};
  assign sx = 18'(cx) - $signed({11'b0, half});
  assign sy = 18'(cy) - $signed({11'b0, half});
  assign phase_inc = phase + 11'd1;

  assign s_axis_tready = state == ST_IDLE;
  assign m_axis_tvalid = state == ST_EMIT;
  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;
  assign last_row = (row + 13'd1) == y1;

  assign m_axis_tdata = {3'b0, object_id, color, addr, x1, x0[11:0], row[11:0]};
  assign m_axis_tlast = last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      canvas_width  <= '0;
      canvas_height <= '0;
      line_width    <= 7'd1;
      line_style    <= STYLE_SOLID;
      object_id     <= 16'hFFFF;
      phase         <= '0;
    end else begin
      if (s_acc) begin
        cx    <= s_axis_tdata[15:0];
        cy    <= s_axis_tdata[31:16];
        color <= s_axis_tdata[63:32];
        if (s_axis_tuser == OP_ADVANCE) begin
          if (line_style == STYLE_DASHED || line_style == STYLE_DOTTED)
            phase <= (phase_inc >= pattern_period(line_style, w)) ? '0 : phase_inc;
          else
            phase <= '0;
        end else if (phase_on(line_style, w, phase)) begin
          state <= ST_CALC;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_CANVAS_WIDTH:  canvas_width <= cfg_data[DIM_W-1:0];
          REG_CANVAS_HEIGHT: canvas_height <= cfg_data[DIM_W-1:0];
          REG_LINE_WIDTH: begin
            line_width <= cfg_data[LW_W-1:0];
            phase      <= '0;
          end
          REG_LINE_STYLE: begin
            line_style <= cfg_data[1:0];
            phase      <= '0;
          end
          REG_OBJECT_ID:     object_id <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_CALC: begin
          x0     <= clip_dim(sx, wclip);
          x1     <= clip_dim(sx + 18'(w), wclip);
          row    <= clip_dim(sy, hclip);
          y1     <= clip_dim(sy + 18'(w), hclip);
          stride <= wclip;
          state  <= ST_MUL;
        end
        ST_MUL: begin
          if (x0 >= x1 || row >= y1) begin
            state <= ST_IDLE;
          end else begin
            addr  <= ADDR_W'(26'(row) * 26'(stride) + 26'(x0));
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (m_acc) begin
            if (last_row) begin
              state <= ST_IDLE;
            end else begin
              row  <= row + 13'd1;
              addr <= addr + ADDR_W'(stride);
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### src/ssbs_checker.sv
// Port-level checks for the styled square brush stamp, bound to the top level.
`default_nettype none
module ssbs_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic                            s_axis_tuser,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [ssbs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                            m_axis_tlast
);
  import ssbs_pkg::*;

  // no new word is taken while a span is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while span pending");

  // a held span keeps its contents
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("span changed while stalled");

  // every span covers at least one column
  a_span_nonempty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[36:24] > {1'b0, m_axis_tdata[23:12]})
    else $error("empty span emitted");

  // an advance word never yields a span
  a_advance_silent: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_ADVANCE |=> !m_axis_tvalid)
    else $error("span after advance");

endmodule

bind styled_square_brush_stamp_core ssbs_checker u_ssbs_checker (.*);
`default_nettype wire

### tb/styled_square_brush_stamp_core_test.sv
// Self-checking stream testbench for the styled square brush stamp core.
`default_nettype none
module styled_square_brush_stamp_core_test;
  import ssbs_pkg::*;

  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [11:0] row;
    logic [11:0] col0;
    logic [12:0] col_end;
    logic [23:0] addr;
    logic [31:0] color;
    logic [15:0] id;
    logic        last;
  } span_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  // model of the block's registers and stipple state
  logic [12:0] cw_reg = '0;
  logic [12:0] ch_reg = '0;
  logic [6:0]  lw_reg = 7'd1;
  style_t      style_reg = STYLE_SOLID;
  logic [15:0] id_reg = 16'hFFFF;
  int          phase_cnt = 0;

  span_t pending_spans[$];
  int    span_faults = 0;
  int    tx_idle_pct = 0;
  int    rx_stall_pct = 0;
  logic  rx_hold = 1'b0;
  event  hold_req;

  styled_square_brush_stamp_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int stipple_period(input style_t st, input int w);
    case (st)
      STYLE_DASHED: return (7 * w + 1) + (15 * w + 1);
      STYLE_DOTTED: return 2 * (3 * w + 1) + (w / 2 + 1) + (12 * w + 1);
      default:      return 1;
    endcase
  endfunction

  function automatic bit stipple_lit(input style_t st, input int w, input int p);
    int a, b, c;
    a = 3 * w + 1;
    b = a + w / 2 + 1;
    c = b + 3 * w + 1;
    case (st)
      STYLE_DASHED: return p >= 7 * w + 1;
      STYLE_DOTTED: return (p >= a && p < b) || p >= c;
      default:      return 1'b1;
    endcase
  endfunction

  function automatic int clamp_to(input int v, input int hi);
    if (v < 0) return 0;
    return (v > hi) ? hi : v;
  endfunction

  function automatic logic [15:0] pick_dim();
    case ($urandom_range(19))
      0, 1:    return 16'd4096;
      2:       return 16'hFFFF;
      3:       return 16'd0;
      default: return 16'($urandom_range(48, 1));
    endcase
  endfunction

  // expected spans of one accepted word
  task automatic stamp_point(input logic op, input logic [15:0] px, input logic [15:0] py,
                             input logic [31:0] color);
    int    w, half, cw, ch, x0, x1, y0, y1;
    span_t s;
    w = (lw_reg > MAX_LINE_WIDTH_DEF) ? MAX_LINE_WIDTH_DEF : int'(lw_reg);
    if (op == OP_ADVANCE) begin
      if (style_reg == STYLE_DASHED || style_reg == STYLE_DOTTED) begin
        phase_cnt++;
        if (phase_cnt >= stipple_period(style_reg, w)) phase_cnt = 0;
      end else begin
        phase_cnt = 0;
      end
    end else if (stipple_lit(style_reg, w, phase_cnt)) begin
      cw = (cw_reg > MAX_CANVAS_DEF) ? MAX_CANVAS_DEF : int'(cw_reg);
      ch = (ch_reg > MAX_CANVAS_DEF) ? MAX_CANVAS_DEF : int'(ch_reg);
      half = w >> 1;
      x0 = clamp_to(int'($signed(px)) - half, cw);
      x1 = clamp_to(int'($signed(px)) - half + w, cw);
      y0 = clamp_to(int'($signed(py)) - half, ch);
      y1 = clamp_to(int'($signed(py)) - half + w, ch);
      if (x0 < x1) begin
        for (int y = y0; y < y1; y++) begin
          s.row = y[11:0];
          s.col0 = x0[11:0];
          s.col_end = x1[12:0];
          s.addr = 24'(y * cw + x0);
          s.color = color;
          s.id = id_reg;
          s.last = (y + 1 == y1);
          pending_spans = {pending_spans, s};
        end
      end
    end
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CANVAS_WIDTH:  cw_reg = val[12:0];
      REG_CANVAS_HEIGHT: ch_reg = val[12:0];
      REG_LINE_WIDTH: begin
        lw_reg = val[6:0];
        phase_cnt = 0;
      end
      REG_LINE_STYLE: begin
        style_reg = style_t'(val[1:0]);
        phase_cnt = 0;
      end
      REG_OBJECT_ID:     id_reg = val;
      default: ;
    endcase
  endtask

  task automatic send_word(input logic op, input logic [15:0] px, input logic [15:0] py,
                           input logic [31:0] color);
    int gap;
    gap = 0;
    while (gap < 64 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {color, py, px};
    do @(posedge clk); while (!s_axis_tready);
    stamp_point(op, px, py, color);
  endtask

  // let every span drain and the block fall idle
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_reset_state();
    write_reg(REG_CANVAS_WIDTH, 16'd16);
    write_reg(REG_CANVAS_HEIGHT, 16'd16);
    send_word(OP_PLOT, 16'd5, 16'd5, 32'h1234_5678);
    send_word(OP_PLOT, 16'hFFFF, 16'd3, 32'h0000_0001);
    send_word(OP_ADVANCE, 16'd0, 16'd0, 32'h0);
    send_word(OP_PLOT, 16'd15, 16'd15, 32'h8000_0000);
    settle();
  endtask

  task automatic test_canvas_extremes();
    write_reg(REG_CANVAS_WIDTH, 16'hFFFF);
    write_reg(REG_CANVAS_HEIGHT, 16'd4096);
    write_reg(REG_LINE_WIDTH, 16'd64);
    write_reg(REG_LINE_STYLE, 16'(STYLE_SOLID));
    write_reg(REG_OBJECT_ID, 16'h7FFF);
    send_word(OP_PLOT, 16'd0, 16'd0, 32'h0000_0000);
    send_word(OP_PLOT, 16'd4095, 16'd4095, 32'hFFFF_FFFF);
    send_word(OP_PLOT, 16'd2048, 16'd1000, 32'hA5A5_5A5A);
    send_word(OP_PLOT, 16'h8000, 16'h8000, 32'h5A5A_A5A5);
    send_word(OP_PLOT, 16'h7FFF, 16'h7FFF, 32'h0F0F_F0F0);
    settle();
    write_reg(REG_LINE_WIDTH, 16'd127);
    write_reg(REG_OBJECT_ID, 16'h8000);
    send_word(OP_PLOT, 16'd100, 16'd4000, 32'hDEAD_BEEF);
    settle();
  endtask

  task automatic test_degenerate_sizes();
    write_reg(REG_CANVAS_WIDTH, 16'd0);
    write_reg(REG_CANVAS_HEIGHT, 16'd20);
    send_word(OP_PLOT, 16'd0, 16'd0, 32'h1111_1111);
    settle();
    write_reg(REG_CANVAS_WIDTH, 16'd20);
    write_reg(REG_CANVAS_HEIGHT, 16'd0);
    send_word(OP_PLOT, 16'd5, 16'd5, 32'h2222_2222);
    settle();
    write_reg(REG_CANVAS_HEIGHT, 16'd20);
    write_reg(REG_LINE_WIDTH, 16'd0);
    send_word(OP_PLOT, 16'd5, 16'd5, 32'h3333_3333);
    settle();
    write_reg(REG_LINE_WIDTH, 16'd3);
    write_reg(REG_LINE_STYLE, 16'(STYLE_RESERVED));
    send_word(OP_PLOT, 16'd10, 16'd10, 32'h4444_4444);
    send_word(OP_ADVANCE, 16'd0, 16'd0, 32'h0);
    send_word(OP_PLOT, 16'd19, 16'd0, 32'h5555_5555);
    settle();
  endtask

  task automatic test_stipple_walk();
    write_reg(REG_CANVAS_WIDTH, 16'd32);
    write_reg(REG_CANVAS_HEIGHT, 16'd32);
    write_reg(REG_LINE_WIDTH, 16'd1);
    write_reg(REG_LINE_STYLE, 16'(STYLE_DOTTED));
    send_word(OP_PLOT, 16'd4, 16'd4, 32'h6666_6666);
    repeat (4) send_word(OP_ADVANCE, 16'd0, 16'd0, 32'h0);
    send_word(OP_PLOT, 16'd7, 16'd9, 32'h7777_7777);
    send_word(OP_ADVANCE, 16'd0, 16'd0, 32'h0);
    send_word(OP_PLOT, 16'd8, 16'd9, 32'h8888_8888);
    settle();
  endtask

  task automatic test_receiver_holdoff();
    write_reg(REG_CANVAS_WIDTH, 16'd64);
    write_reg(REG_CANVAS_HEIGHT, 16'd64);
    write_reg(REG_LINE_WIDTH, 16'd8);
    write_reg(REG_LINE_STYLE, 16'(STYLE_SOLID));
    -> hold_req;
    for (int i = 0; i < 6; i++) send_word(OP_PLOT, 16'(20 + 5 * i), 16'd30, $urandom);
    settle();
  endtask

  task automatic test_random(input int tx_pct, input int rx_pct);
    logic        op;
    logic [15:0] px, py;
    int          t, reach_x, reach_y, adv_pct;
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (2) begin
      settle();
      write_reg(REG_CANVAS_WIDTH, pick_dim());
      write_reg(REG_CANVAS_HEIGHT, pick_dim());
      case ($urandom_range(19))
        0, 1:    write_reg(REG_LINE_WIDTH, 16'd64);
        2:       write_reg(REG_LINE_WIDTH, 16'd127);
        3:       write_reg(REG_LINE_WIDTH, 16'd0);
        4:       write_reg(REG_LINE_WIDTH, 16'($urandom_range(40, 5)));
        default: write_reg(REG_LINE_WIDTH, 16'($urandom_range(3, 1)));
      endcase
      write_reg(REG_LINE_STYLE, 16'($urandom_range(3)));
      write_reg(REG_OBJECT_ID, 16'($urandom));
      reach_x = (cw_reg > MAX_CANVAS_DEF) ? MAX_CANVAS_DEF : int'(cw_reg);
      reach_y = (ch_reg > MAX_CANVAS_DEF) ? MAX_CANVAS_DEF : int'(ch_reg);
      adv_pct = (style_reg == STYLE_DASHED || style_reg == STYLE_DOTTED) ? 50 : 10;
      for (int i = 0; i < 16; i++) begin
        op = ($urandom_range(99) < adv_pct) ? OP_ADVANCE : OP_PLOT;
        if ($urandom_range(99) < 15) begin
          px = 16'($urandom);
          py = 16'($urandom);
        end else begin
          t = int'($urandom_range(reach_x + 16)) - 8;
          px = t[15:0];
          t = int'($urandom_range(reach_y + 16)) - 8;
          py = t[15:0];
        end
        send_word(op, px, py, $urandom);
      end
    end
  endtask

  always begin
    @(hold_req);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    span_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.row = m_axis_tdata[11:0];
      got.col0 = m_axis_tdata[23:12];
      got.col_end = m_axis_tdata[36:24];
      got.addr = m_axis_tdata[60:37];
      got.color = m_axis_tdata[92:61];
      got.id = m_axis_tdata[108:93];
      got.last = m_axis_tlast;
      if (pending_spans.size() == 0) begin
        if (span_faults < 10)
          $display("unexpected span: row %0d start %0d end %0d", got.row, got.col0,
                   got.col_end);
        span_faults++;
      end else begin
        want = pending_spans.pop_front();
        if (got !== want) begin
          if (span_faults < 10) begin
            $display("span mismatch: expected row %0d start %0d end %0d addr %h color %h",
                     want.row, want.col0, want.col_end, want.addr, want.color);
            $display("  id %h last %b; got row %0d start %0d end %0d addr %h color %h",
                     want.id, want.last, got.row, got.col0, got.col_end, got.addr,
                     got.color);
            $display("  id %h last %b", got.id, got.last);
          end
          span_faults++;
        end
      end
    end
    m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  initial begin
    #5_000_000;
    $display("styled_square_brush_stamp_core_test: done, errors");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_canvas_extremes();
    test_degenerate_sizes();
    test_stipple_walk();
    test_receiver_holdoff();
    test_random(0, 0);
    test_random(88, 0);
    test_random(0, 88);
    test_random(32, 32);
    settle();
    if (span_faults == 0) begin
      $display("styled_square_brush_stamp_core_test: done, clean");
    end else begin
      $display("styled_square_brush_stamp_core_test: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
